/* hdl/tmt_pkg.sv */
// Shared constants and types for the trimmed-mean-of-ten block.
// No dependencies.
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int BATCH_SIZE  = 10;
  localparam int SAMPLE_BITS = 24;
  localparam int AVG_BITS    = 24;
  // ten samples need four extra bits of headroom
  localparam int SUM_BITS    = SAMPLE_BITS + 4;
  localparam int CNT_BITS    = 4;
  // eight kept samples: divide by shifting
  localparam int KEEP_SHIFT  = 3;

  localparam logic [CNT_BITS-1:0] LAST_COUNT = CNT_BITS'(BATCH_SIZE - 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [AVG_BITS-1:0]    avg_t;

  // Totals of one finished batch, passed from accumulator to result stage.
  typedef struct packed {
    sum_t    running_sum;
    sample_t largest;
    sample_t smallest;
  } tmt_batch_t;

endpackage

/* hdl/trimmed_mean_of_ten.sv */
// Trimmed mean of ten: drops max and min of each ten-sample batch, averages the rest.
// Throughput: one sample per cycle while the result path does not stall; one result per ten samples.
// Tenth sample to out_valid: input register (smp_r), batch capture register (fin_r), output register.
// Rate set by the sum/max/min update in tmt_accum.
// Reset (rst_n low, synchronous): empties all stages and starts a new batch.
// Depends on tmt_pkg, tmt_accum, tmt_result.
`timescale 1ns / 1ps

module trimmed_mean_of_ten import tmt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  sample_t in_sample,
  output logic    out_valid,
  input  logic    out_ready,
  output avg_t    out_average
);

  logic       done_valid;
  logic       done_ready;
  tmt_batch_t done;

  tmt_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done       (done)
  );

  tmt_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .done        (done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average)
  );

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    done_valid |-> (done.smallest <= done.largest))
    else $error("batch min above max");

  a_sum_holds_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    done_valid |-> (done.running_sum >=
                    (SUM_BITS'(done.largest) + SUM_BITS'(done.smallest))))
    else $error("batch sum smaller than its extremes");

  a_batch_held: assert property (@(posedge clk) disable iff (!rst_n)
    (done_valid && !done_ready) |=> (done_valid && $stable(done)))
    else $error("stalled batch changed");

endmodule

/* hdl/tmt_accum.sv */
// Input register and batch accumulator (running sum, max, min, count).
// Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_accum import tmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sample_t    in_sample,
  output logic       done_valid,
  input  logic       done_ready,
  output tmt_batch_t done
);

  logic                smp_vld_r;
  sample_t             smp_r;
  logic [CNT_BITS-1:0] count_r;
  sum_t                sum_r;
  sample_t             max_r;
  sample_t             min_r;

  logic    last;
  logic    acc_go;
  sum_t    sum_nxt;
  sample_t max_nxt;
  sample_t min_nxt;

  assign last   = (count_r == LAST_COUNT);
  assign acc_go = smp_vld_r && (!last || done_ready);

  assign in_ready = !smp_vld_r || acc_go;

  assign sum_nxt = sum_r + SUM_BITS'(smp_r);
  assign max_nxt = (smp_r > max_r) ? smp_r : max_r;
  assign min_nxt = (smp_r < min_r) ? smp_r : min_r;

  assign done_valid        = smp_vld_r && last;
  assign done.running_sum  = sum_nxt;
  assign done.largest      = max_nxt;
  assign done.smallest     = min_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
    end else if (in_ready) begin
      smp_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      smp_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      max_r   <= '0;
      min_r   <= '1;
    end else if (acc_go) begin
      if (last) begin
        // batch handed off, start over
        count_r <= '0;
        sum_r   <= '0;
        max_r   <= '0;
        min_r   <= '1;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_nxt;
        max_r   <= max_nxt;
        min_r   <= min_nxt;
      end
    end
  end

endmodule

/* hdl/tmt_result.sv */
// Batch capture register, trim and divide, and output register.
// Depends on tmt_pkg.
`timescale 1ns / 1ps

module tmt_result import tmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       done_valid,
  output logic       done_ready,
  input  tmt_batch_t done,
  output logic       out_valid,
  input  logic       out_ready,
  output avg_t       out_average
);

  logic       fin_vld_r;
  tmt_batch_t fin_r;
  logic       out_vld_r;
  avg_t       avg_r;

  logic fin_go;
  logic out_free;
  sum_t trimmed;
  avg_t avg_nxt;

  assign out_free   = !out_vld_r || out_ready;
  assign fin_go     = fin_vld_r && out_free;
  assign done_ready = !fin_vld_r || fin_go;

  // sum always contains both extremes, so no underflow
  assign trimmed = fin_r.running_sum - SUM_BITS'(fin_r.largest)
                   - SUM_BITS'(fin_r.smallest);
  assign avg_nxt = AVG_BITS'(trimmed >> KEEP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (done_ready) begin
      fin_vld_r <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      fin_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fin_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      avg_r <= avg_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_average = avg_r;

endmodule
